### rtl/edge_triggered_pretrigger_capture_assert.svh
// Assertion macros shared by the capture RTL.
`ifndef EDGE_TRIGGERED_PRETRIGGER_CAPTURE_ASSERT_SVH
`define EDGE_TRIGGERED_PRETRIGGER_CAPTURE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ETPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ETPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/etpc_pkg.sv
// Shared types and constants for the pretrigger capture block.
`timescale 1ns / 1ps
package etpc_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned LEVEL_W    = 12;
  localparam int unsigned EDGE_W     = 2;
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned OFF_W      = 9;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_ARM    = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  // Capture phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PREFILL = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TRIG    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;

  // Trigger edge select codes
  localparam logic [EDGE_W-1:0] EDGE_RISE = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_FALL = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_ANY  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET  = 12'd2100;
  localparam logic [EDGE_W-1:0]  EDGE_RESET   = EDGE_ANY;
  localparam logic [LEN_W-1:0]   LENGTH_RESET = 10'd512;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               done;
    logic               hit;
  } item_stat_t;

endpackage

### rtl/edge_triggered_pretrigger_capture.sv
// Top level of the edge-triggered pretrigger capture block.
// Throughput: one item per cycle while out_ready_i does not stall the output;
// the store has a registered read port, so each result passes a read stage
// and then an output register before it is valid.
// Reset clears the capture state, the configuration registers and the
// pipeline valids; the sample store is not cleared and needs no sweep.
`timescale 1ns / 1ps
module edge_triggered_pretrigger_capture #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [etpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [etpc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [etpc_pkg::ACTION_W-1:0]    action_i,
  input  logic [etpc_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic [etpc_pkg::OFF_W-1:0]       read_offset_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [etpc_pkg::PHASE_W-1:0]     phase_o,
  output logic                             capture_done_o,
  output logic [etpc_pkg::SAMPLE_W-1:0]    read_data_o,
  output logic                             read_valid_o
);
  import etpc_pkg::*;
`include "edge_triggered_pretrigger_capture_assert.svh"

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic                take;
  item_stat_t          stat;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0] mem_wdata, mem_rdata;

  // Read stage: status of the item whose store read is in flight
  logic                s1_v_q;
  item_stat_t          s1_stat_q;
  logic                s1_go;

  // Output register
  logic                out_v_q;
  logic [PHASE_W-1:0]  phase_q;
  logic                done_q;
  logic [SAMPLE_W-1:0] rdata_q;
  logic                rvalid_q;

  // Configuration writes never stall
  assign cfg_ready_o = 1'b1;

  // Advance the read stage whenever the output register is free or draining
  assign s1_go      = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_go;
  assign take       = in_valid_i && in_ready_o;

  etpc_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .take_i        (take),
    .action_i      (action_i),
    .sample_i      (sample_i),
    .read_offset_i (read_offset_i),
    .stat_o        (stat),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr)
  );

  // Read data holds between reads, so a stalled read stage keeps its sample
  etpc_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .DW    (SAMPLE_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (take) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_stat_q <= stat;
    end
    if (s1_go) begin
      phase_q  <= s1_stat_q.phase;
      done_q   <= s1_stat_q.done;
      rvalid_q <= s1_stat_q.hit;
      rdata_q  <= s1_stat_q.hit ? mem_rdata : '0;
    end
  end

  assign out_valid_o    = out_v_q;
  assign phase_o        = phase_q;
  assign capture_done_o = done_q;
  assign read_data_o    = rdata_q;
  assign read_valid_o   = rvalid_q;

  `ETPC_ASSERT_NOW(a_done_in_complete, out_valid_o && capture_done_o, phase_o == PH_DONE, "capture_done outside complete phase")
  `ETPC_ASSERT_NOW(a_read_in_complete, out_valid_o && read_valid_o, phase_o == PH_DONE, "read_valid outside complete phase")
  `ETPC_ASSERT_NOW(a_miss_reads_zero, out_valid_o && !read_valid_o, read_data_o == '0, "nonzero read_data on a miss")
  `ETPC_ASSERT_NEXT(a_take_fills_stage, take, s1_v_q, "accepted item lost before the read stage")

endmodule

### rtl/etpc_store.sv
// Sample ring store: one write port, one read port with registered data.
`timescale 1ns / 1ps
module etpc_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/etpc_ctrl.sv
// Configuration registers, capture state and per-item next-state logic.
`timescale 1ns / 1ps
module etpc_ctrl #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned AW          = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [etpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [etpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                take_i,
  input  logic [etpc_pkg::ACTION_W-1:0]       action_i,
  input  logic [etpc_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic [etpc_pkg::OFF_W-1:0]          read_offset_i,
  output etpc_pkg::item_stat_t                stat_o,
  output logic                                mem_we_o,
  output logic [AW-1:0]                       mem_waddr_o,
  output logic [etpc_pkg::SAMPLE_W-1:0]       mem_wdata_o,
  output logic                                mem_re_o,
  output logic [AW-1:0]                       mem_raddr_o
);
  import etpc_pkg::*;

  localparam int unsigned CW = (AW > LEN_W) ? AW : LEN_W;
  localparam logic [AW-1:0] HALF_DEPTH = AW'(STORE_DEPTH / 2);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(STORE_DEPTH - 1);

  logic [LEVEL_W-1:0]  level_q;
  logic [EDGE_W-1:0]   edge_q;
  logic [LEN_W-1:0]    length_q;

  logic [AW-1:0]       wp_q, wp_d;
  logic [AW-1:0]       sc_q, sc_d;
  logic [AW-1:0]       ws_q, ws_d;
  logic [AW-1:0]       wf_q, wf_d;
  logic [SAMPLE_W-1:0] prev_q, prev_d;
  logic [PHASE_W-1:0]  ph_q, ph_d;

  logic [CW-1:0]       len;
  logic [AW-1:0]       half;
  logic [AW-1:0]       wp_inc;
  logic [AW-1:0]       sc_inc;
  logic [AW-1:0]       wf_inc;
  logic [AW-1:0]       ws_trig;
  logic [CW:0]         rsum;
  logic                up, down, fire, active;
  logic                done, hit;

  // Window length saturates at half the store
  assign len  = (CW'(length_q) > CW'(HALF_DEPTH)) ? CW'(HALF_DEPTH) : CW'(length_q);
  assign half = len[AW-1:0] >> 1;

  assign wp_inc = (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
  assign sc_inc = (sc_q < HALF_DEPTH) ? sc_q + 1'b1 : sc_q;
  assign wf_inc = (wf_q < HALF_DEPTH) ? wf_q + 1'b1 : wf_q;
  assign ws_trig = (wp_inc >= half) ? wp_inc - half :
                   AW'((AW+1)'(wp_inc) + (AW+1)'(STORE_DEPTH) - (AW+1)'(half));

  assign down = (prev_q > level_q) && (sample_i <= level_q);
  assign up   = (prev_q < level_q) && (sample_i >= level_q);
  assign fire = ((edge_q != EDGE_RISE) && down) || ((edge_q != EDGE_FALL) && up);

  assign active = (ph_q == PH_PREFILL) || (ph_q == PH_WAIT) || (ph_q == PH_TRIG);

  // Window read address, wrapped once around the ring
  assign rsum = (CW+1)'(ws_q) + (CW+1)'(read_offset_i);
  assign mem_raddr_o = (rsum >= (CW+1)'(STORE_DEPTH)) ?
                       AW'(rsum - (CW+1)'(STORE_DEPTH)) : AW'(rsum);

  assign mem_waddr_o = wp_q;
  assign mem_wdata_o = sample_i;

  always_comb begin
    wp_d     = wp_q;
    sc_d     = sc_q;
    ws_d     = ws_q;
    wf_d     = wf_q;
    prev_d   = prev_q;
    ph_d     = ph_q;
    done     = 1'b0;
    hit      = 1'b0;
    mem_we_o = 1'b0;
    mem_re_o = 1'b0;
    if (take_i) begin
      case (action_e'(action_i))
        ACT_SAMPLE: begin
          if (active) begin
            mem_we_o = 1'b1;
            wp_d     = wp_inc;
            sc_d     = sc_inc;
            if (ph_q == PH_TRIG) begin
              wf_d = wf_inc;
              if (CW'(wf_inc) >= len) begin
                ph_d = PH_DONE;
                done = 1'b1;
              end
            end else if (sc_inc < half) begin
              prev_d = sample_i;
              ph_d   = PH_PREFILL;
            end else begin
              prev_d = sample_i;
              if (fire) begin
                ph_d = PH_TRIG;
                ws_d = ws_trig;
                wf_d = half;
              end else begin
                ph_d = PH_WAIT;
              end
            end
          end
        end
        ACT_ARM: begin
          wp_d   = '0;
          sc_d   = '0;
          ws_d   = '0;
          wf_d   = '0;
          prev_d = level_q - 1'b1;
          ph_d   = PH_PREFILL;
        end
        ACT_READ: begin
          if ((ph_q == PH_DONE) && (CW'(read_offset_i) < CW'(wf_q))) begin
            hit      = 1'b1;
            mem_re_o = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat_o = '{phase: ph_d, done: done, hit: hit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= LEVEL_RESET;
      edge_q   <= EDGE_RESET;
      length_q <= LENGTH_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LEVEL:  level_q  <= cfg_data_i[LEVEL_W-1:0];
        REG_EDGE:   edge_q   <= cfg_data_i[EDGE_W-1:0];
        REG_LENGTH: length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      sc_q   <= '0;
      ws_q   <= '0;
      wf_q   <= '0;
      prev_q <= LEVEL_RESET - 1'b1;
      ph_q   <= PH_IDLE;
    end else begin
      wp_q   <= wp_d;
      sc_q   <= sc_d;
      ws_q   <= ws_d;
      wf_q   <= wf_d;
      prev_q <= prev_d;
      ph_q   <= ph_d;
    end
  end

endmodule
